@@ rtl/skt_pkg.sv @@
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants of the sorted key/tag table
// Item formats, status and mode codes, the entry record and the cell controls.
// ----------------------------------------------------------------------------
package skt_pkg;

	localparam int TABLE_ENTRIES  = 64;
	localparam int TAGS_PER_ENTRY = 8;
	localparam int KEY_WIDTH      = 32;
	localparam int TAG_WIDTH      = 32;

	localparam int IDX_W  = $clog2(TABLE_ENTRIES);
	localparam int ECNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int TIDX_W = (TAGS_PER_ENTRY > 1) ? $clog2(TAGS_PER_ENTRY) : 1;
	localparam int TCNT_W = $clog2(TAGS_PER_ENTRY + 1);

	localparam logic [1:0] MODE_PUT    = 2'd0;
	localparam logic [1:0] MODE_READ   = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;
	localparam logic [1:0] MODE_QUERY  = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_TOO_MANY  = 2'd3;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] key;
		logic [31:0] tag;
		logic        has_tag;
		logic        last;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] out_key;
		logic [31:0] out_tag;
		logic        has_value;
		logic        end_of_run;
	} rsp_t;

	typedef struct packed {
		logic [KEY_WIDTH-1:0]                     key;
		logic [TCNT_W-1:0]                        cnt;
		logic [TAGS_PER_ENTRY-1:0][TAG_WIDTH-1:0] tags;
	} entry_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_NEW,
		CELL_LEFT,
		CELL_RIGHT,
		CELL_TAGS
	} cell_op_t;

	typedef struct packed {
		logic key_lt;
		logic key_eq;
		logic tag_hit;
	} cell_flags_t;

endpackage

@@ rtl/skt_cell.sv @@
// ----------------------------------------------------------------------------
// skt_cell: one table slot
// Holds one entry, compares it against the probe key and tag, and loads from
// the new entry or a neighbor when the row shifts.
// ----------------------------------------------------------------------------
module skt_cell
	import skt_pkg::*;
(
	input  logic                 clk,
	input  cell_op_t             op,
	input  logic                 slot_valid,
	input  entry_t               new_entry,
	input  entry_t               left_entry,
	input  entry_t               right_entry,
	input  logic [KEY_WIDTH-1:0] probe_key,
	input  logic [TAG_WIDTH-1:0] probe_tag,
	output entry_t               entry,
	output cell_flags_t          flags
);

	entry_t entry_q;

	always_ff @(posedge clk) begin
		unique case (op)
			CELL_NEW:   entry_q <= new_entry;
			CELL_LEFT:  entry_q <= left_entry;
			CELL_RIGHT: entry_q <= right_entry;
			CELL_TAGS: begin
				entry_q.cnt  <= new_entry.cnt;
				entry_q.tags <= new_entry.tags;
			end
			default:    entry_q <= entry_q;
		endcase
	end

	always_comb begin
		logic hit;
		hit = 1'b0;
		for (int j = 0; j < TAGS_PER_ENTRY; j++) begin
			if ((TCNT_W'(j) < entry_q.cnt) && (entry_q.tags[j] == probe_tag))
				hit = 1'b1;
		end
		flags.tag_hit = hit;
		flags.key_lt  = slot_valid && (entry_q.key < probe_key);
		flags.key_eq  = slot_valid && (entry_q.key == probe_key);
	end

	assign entry = entry_q;

endmodule

@@ rtl/sorted_key_tag_table.sv @@
// ----------------------------------------------------------------------------
// sorted_key_tag_table: sorted key table with tag lists and subset query
// A row of cells keeps entries in ascending key order; inserts and removes
// shift the row by one slot.
// ----------------------------------------------------------------------------
//  channel   signals              handshake
//  command   start, busy, cmd     taken when start && !busy
//  result    done, rsp            one cycle per result, no backpressure
//
// A tag list item without last is only staged. Put, remove and a not-found
// read are accepted and then carried out on the row in S_EXEC. A read of a
// present key then returns its tags in order, one result each. A query tests
// the row with one broadcast staged tag per cycle, then sees the end of the
// list, then returns each matching key, or one empty result when none match.
// Reset clears the entry count, staging and the controller; cell contents
// are left as they are and are only read below the entry count.
// busy is high while an item is in work; results cannot be stalled.
// ----------------------------------------------------------------------------
module sorted_key_tag_table
	import skt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output rsp_t rsp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_QTEST,
		S_QEMIT
	} state_t;

	state_t                                   state_q;
	logic [1:0]                               mode_q;
	logic [KEY_WIDTH-1:0]                     key_q;
	logic [ECNT_W-1:0]                        entry_count_q;
	logic [TAGS_PER_ENTRY-1:0][TAG_WIDTH-1:0] stg_tags_q;
	logic [TCNT_W-1:0]                        stg_cnt_q;
	logic                                     stg_ovf_q;
	logic [TCNT_W-1:0]                        step_q;
	entry_t                                   rd_q;
	logic [TABLE_ENTRIES-1:0]                 match_q;
	logic                                     done_q;
	rsp_t                                     rsp_q;

	entry_t      entries [TABLE_ENTRIES];
	cell_flags_t flags   [TABLE_ENTRIES];
	cell_op_t    ops     [TABLE_ENTRIES];
	logic        slot_ok [TABLE_ENTRIES];
	entry_t      new_entry;

	logic                     accept;
	logic                     found;
	logic                     full;
	entry_t                   hit_entry;
	logic [TABLE_ENTRIES-1:0] hit_vec;
	logic [TABLE_ENTRIES-1:0] sel_vec;
	logic [TABLE_ENTRIES-1:0] rest_vec;
	logic [KEY_WIDTH-1:0]     sel_key;
	logic [TAG_WIDTH-1:0]     probe_tag;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign rsp    = rsp_q;
	assign full   = (entry_count_q == ECNT_W'(TABLE_ENTRIES));

	assign new_entry.key  = key_q;
	assign new_entry.cnt  = stg_cnt_q;
	assign new_entry.tags = stg_tags_q;

	// the staged tag under test is broadcast to every cell
	assign probe_tag = stg_tags_q[step_q[TIDX_W-1:0]];

	// ---- the cell row ----
	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		entry_t left_e, right_e;
		if (i == 0) begin : g_first
			assign left_e = new_entry;
		end else begin : g_mid
			assign left_e = entries[i-1];
		end
		if (i == TABLE_ENTRIES - 1) begin : g_last
			assign right_e = entries[i];
		end else begin : g_nmid
			assign right_e = entries[i+1];
		end
		assign slot_ok[i] = (ECNT_W'(i) < entry_count_q);

		skt_cell u_cell (
			.clk         (clk),
			.op          (ops[i]),
			.slot_valid  (slot_ok[i]),
			.new_entry   (new_entry),
			.left_entry  (left_e),
			.right_entry (right_e),
			.probe_key   (key_q),
			.probe_tag   (probe_tag),
			.entry       (entries[i]),
			.flags       (flags[i])
		);
	end

	// key hit, selected entry for a read, and lowest remaining query match
	always_comb begin
		hit_entry = '0;
		sel_key   = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			hit_vec[i] = flags[i].key_eq;
			if (flags[i].key_eq)
				hit_entry = hit_entry | entries[i];
		end
		found    = |hit_vec;
		sel_vec  = match_q & (~match_q + TABLE_ENTRIES'(1));
		rest_vec = match_q & ~sel_vec;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (sel_vec[i])
				sel_key = sel_key | entries[i].key;
		end
	end

	// per-cell load control: lt cells keep, the slot at pos takes the new entry on
	// insert or the new tags on a put to a present key; on insert and remove the rest shift one slot
	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			ops[i] = CELL_HOLD;
			if (state_q == S_EXEC) begin
				unique case (mode_q)
					MODE_PUT: begin
						if (!stg_ovf_q) begin
							if (found) begin
								if (flags[i].key_eq)
									ops[i] = CELL_TAGS;
							end else if (!full && !flags[i].key_lt) begin
								if (i == 0)
									ops[i] = CELL_NEW;
								else if (flags[i-1].key_lt || !slot_ok[i-1])
									ops[i] = CELL_NEW;
								else
									ops[i] = CELL_LEFT;
							end
						end
					end
					MODE_REMOVE: begin
						if (found && !flags[i].key_lt)
							ops[i] = CELL_RIGHT;
					end
					default: ops[i] = CELL_HOLD;
				endcase
			end
		end
	end

	// controller, staging and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			entry_count_q <= '0;
			stg_tags_q    <= '0;
			stg_cnt_q     <= '0;
			stg_ovf_q     <= 1'b0;
			done_q        <= 1'b0;
			mode_q        <= MODE_PUT;
			key_q         <= '0;
			step_q        <= '0;
			rd_q          <= '0;
			match_q       <= '0;
			rsp_q         <= '0;
		end else begin
			done_q <= 1'b0;
			rsp_q  <= '0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q <= cmd.mode;
						key_q  <= cmd.key;
						if (cmd.mode == MODE_READ || cmd.mode == MODE_REMOVE) begin
							stg_cnt_q <= '0;
							stg_ovf_q <= 1'b0;
							state_q   <= S_EXEC;
						end else begin
							if (cmd.has_tag) begin
								if (stg_cnt_q < TCNT_W'(TAGS_PER_ENTRY)) begin
									stg_tags_q[stg_cnt_q[TIDX_W-1:0]] <= cmd.tag;
									stg_cnt_q <= stg_cnt_q + 1'b1;
								end else begin
									stg_ovf_q <= 1'b1;
								end
							end
							if (cmd.last)
								state_q <= S_EXEC;
						end
					end
				end
				S_EXEC: begin
					unique case (mode_q)
						MODE_PUT: begin
							done_q              <= 1'b1;
							rsp_q.end_of_run    <= 1'b1;
							stg_cnt_q           <= '0;
							stg_ovf_q           <= 1'b0;
							state_q             <= S_IDLE;
							if (stg_ovf_q)
								rsp_q.status <= ST_TOO_MANY;
							else if (!found && full)
								rsp_q.status <= ST_FULL;
							else begin
								rsp_q.status <= ST_OK;
								if (!found)
									entry_count_q <= entry_count_q + 1'b1;
							end
						end
						MODE_REMOVE: begin
							done_q           <= 1'b1;
							rsp_q.end_of_run <= 1'b1;
							state_q          <= S_IDLE;
							if (found) begin
								rsp_q.status  <= ST_OK;
								entry_count_q <= entry_count_q - 1'b1;
							end else
								rsp_q.status <= ST_NOT_FOUND;
						end
						MODE_READ: begin
							rd_q   <= hit_entry;
							step_q <= '0;
							if (!found || hit_entry.cnt == '0) begin
								done_q           <= 1'b1;
								rsp_q.end_of_run <= 1'b1;
								rsp_q.status     <= found ? ST_OK : ST_NOT_FOUND;
								state_q          <= S_IDLE;
							end else
								state_q <= S_READ;
						end
						default: begin
							// query
							if (stg_ovf_q) begin
								done_q           <= 1'b1;
								rsp_q.end_of_run <= 1'b1;
								rsp_q.status     <= ST_TOO_MANY;
								stg_cnt_q        <= '0;
								stg_ovf_q        <= 1'b0;
								state_q          <= S_IDLE;
							end else begin
								for (int i = 0; i < TABLE_ENTRIES; i++)
									match_q[i] <= slot_ok[i];
								step_q  <= '0;
								state_q <= S_QTEST;
							end
						end
					endcase
				end
				S_READ: begin
					done_q          <= 1'b1;
					rsp_q.status    <= ST_OK;
					rsp_q.has_value <= 1'b1;
					rsp_q.out_tag   <= rd_q.tags[step_q[TIDX_W-1:0]];
					step_q          <= step_q + 1'b1;
					if (step_q + 1'b1 == rd_q.cnt) begin
						rsp_q.end_of_run <= 1'b1;
						state_q          <= S_IDLE;
					end
				end
				S_QTEST: begin
					if (step_q == stg_cnt_q) begin
						stg_cnt_q <= '0;
						stg_ovf_q <= 1'b0;
						state_q   <= S_QEMIT;
					end else begin
						for (int i = 0; i < TABLE_ENTRIES; i++)
							match_q[i] <= match_q[i] & flags[i].tag_hit;
						step_q <= step_q + 1'b1;
					end
				end
				S_QEMIT: begin
					done_q       <= 1'b1;
					rsp_q.status <= ST_OK;
					if (match_q == '0) begin
						// nothing matched at all
						rsp_q.end_of_run <= 1'b1;
						state_q          <= S_IDLE;
					end else begin
						rsp_q.has_value  <= 1'b1;
						rsp_q.out_key    <= sel_key;
						match_q          <= rest_vec;
						if (rest_vec == '0) begin
							rsp_q.end_of_run <= 1'b1;
							state_q          <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---- checks ----
	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.end_of_run |=> !done)
		else $error("result after end of run");

	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done && !rsp.end_of_run |-> busy)
		else $error("open run while idle");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= ECNT_W'(TABLE_ENTRIES))
		else $error("entry count overflow");

	a_stage_range: assert property (@(posedge clk) disable iff (!arst_n)
		stg_cnt_q <= TCNT_W'(TAGS_PER_ENTRY))
		else $error("staging count overflow");

endmodule

@@ tb/sv/skt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_checker: result predictor and scoreboard for the sorted key/tag table
// Watches accepted commands, keeps its own copy of the table, queues the
// expected responses and compares each strobed response field by field.
// ----------------------------------------------------------------------------
module skt_checker
	import skt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  cmd_t cmd,
	input  logic done,
	input  rsp_t rsp,
	output int   fail_count,
	output int   pending
);

	logic [31:0] tbl_key [TABLE_ENTRIES];
	logic [31:0] tbl_tag [TABLE_ENTRIES][TAGS_PER_ENTRY];
	int          tbl_cnt [TABLE_ENTRIES];
	int          n_entries;
	logic [31:0] stage [TAGS_PER_ENTRY];
	int          n_stage;
	bit          stage_ovf;
	rsp_t        rsp_q[$];

	assign pending = rsp_q.size();

	function automatic rsp_t mk(logic [1:0] st, logic [31:0] k, logic [31:0] t,
			logic hv, logic e);
		rsp_t r;
		r.status = st; r.out_key = k; r.out_tag = t; r.has_value = hv; r.end_of_run = e;
		return r;
	endfunction

	function automatic int lower_bound(logic [31:0] k);
		int i;
		i = 0;
		while (i < n_entries && tbl_key[i] < k) i++;
		return i;
	endfunction

	function automatic bit entry_holds(int e, logic [31:0] t);
		for (int j = 0; j < tbl_cnt[e]; j++)
			if (tbl_tag[e][j] == t) return 1;
		return 0;
	endfunction

	task automatic shift_entry(int dst, int src);
		tbl_key[dst] = tbl_key[src];
		tbl_cnt[dst] = tbl_cnt[src];
		for (int j = 0; j < TAGS_PER_ENTRY; j++) tbl_tag[dst][j] = tbl_tag[src][j];
	endtask

	task automatic predict_table(cmd_t c);
		int pos;
		int hits;
		bit found;
		logic [1:0] st;
		bit ok;
		pos = lower_bound(c.key);
		found = (pos < n_entries) && (tbl_key[pos] == c.key);
		if (c.mode == MODE_READ || c.mode == MODE_REMOVE) begin
			// read/remove drops any partial list
			n_stage = 0; stage_ovf = 0;
			if (!found) begin
				rsp_q.push_back(mk(ST_NOT_FOUND, 0, 0, 0, 1));
			end else if (c.mode == MODE_REMOVE) begin
				for (int i = pos; i + 1 < n_entries; i++) shift_entry(i, i + 1);
				n_entries--;
				rsp_q.push_back(mk(ST_OK, 0, 0, 0, 1));
			end else if (tbl_cnt[pos] == 0) begin
				rsp_q.push_back(mk(ST_OK, 0, 0, 0, 1));
			end else begin
				for (int i = 0; i < tbl_cnt[pos]; i++)
					rsp_q.push_back(mk(ST_OK, 0, tbl_tag[pos][i], 1, i + 1 == tbl_cnt[pos]));
			end
			return;
		end
		if (c.has_tag) begin
			if (n_stage < TAGS_PER_ENTRY) stage[n_stage++] = c.tag;
			else stage_ovf = 1;
		end
		if (!c.last) return;
		if (c.mode == MODE_PUT) begin
			if (stage_ovf) st = ST_TOO_MANY;
			else if (!found && n_entries >= TABLE_ENTRIES) st = ST_FULL;
			else begin
				if (!found) begin
					for (int i = n_entries; i > pos; i--) shift_entry(i, i - 1);
					n_entries++;
					tbl_key[pos] = c.key;
				end
				tbl_cnt[pos] = n_stage;
				for (int i = 0; i < n_stage; i++) tbl_tag[pos][i] = stage[i];
				st = ST_OK;
			end
			rsp_q.push_back(mk(st, 0, 0, 0, 1));
		end else if (stage_ovf) begin
			rsp_q.push_back(mk(ST_TOO_MANY, 0, 0, 0, 1));
		end else begin
			hits = 0;
			for (int i = 0; i < n_entries; i++) begin
				ok = 1;
				for (int j = 0; j < n_stage && ok; j++) ok = entry_holds(i, stage[j]);
				if (ok) begin
					rsp_q.push_back(mk(ST_OK, tbl_key[i], 0, 1, 0));
					hits++;
				end
			end
			if (hits == 0) rsp_q.push_back(mk(ST_OK, 0, 0, 0, 1));
			else rsp_q[$].end_of_run = 1;
		end
		n_stage = 0; stage_ovf = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			n_entries = 0; n_stage = 0; stage_ovf = 0;
			fail_count = 0;
			rsp_q.delete();
		end else begin
			// response first: it belongs to an earlier command
			if (done) begin
				if (rsp_q.size() == 0) begin
					$display("%0t: unexpected response %p", $time, rsp);
					fail_count++;
				end else begin
					want = rsp_q.pop_front();
					if (rsp !== want) begin
						$display("%0t: mismatch expected %p actual %p", $time, want, rsp);
						fail_count++;
					end
				end
			end
			if (start && !busy) predict_table(cmd);
		end
	end

endmodule

@@ tb/sv/tb_sorted_key_tag_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_key_tag_table: stimulus and verdict for the sorted key/tag table
// Directed puts, reads, removes and queries over the corner cases, a table
// fill to capacity, then random command sequences with idle bursts.
// ----------------------------------------------------------------------------
module tb_sorted_key_tag_table;
	import skt_pkg::*;

	localparam int LIMIT = 400000;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic done;
	cmd_t cmd = '0;
	rsp_t rsp;
	int   fails;
	int   pending;
	int   cycles = 0;
	bit   idling = 1;
	int   n_items = 0;
	logic [31:0] keys [8];
	logic [31:0] tags [6];

	always #6 clk = ~clk;

	sorted_key_tag_table dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .rsp(rsp)
	);

	skt_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .rsp(rsp), .fail_count(fails), .pending(pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// present one command and hold it until the block takes it
	task automatic issue(logic [1:0] m, logic [31:0] k, logic [31:0] t, logic ht, logic l);
		int gap;
		if (idling && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		cmd <= '{mode: m, key: k, tag: t, has_tag: ht, last: l};
		@(posedge clk);
		while (busy) @(posedge clk);
		n_items++;
	endtask

	task automatic go_quiet();
		start <= 0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
	endtask

	// tag list of n entries ending with last in mode m
	task automatic send_list(logic [1:0] m, logic [31:0] k, int n);
		if (n == 0) issue(m, k, $urandom, 0, 1);
		for (int i = 0; i < n; i++)
			issue(m, k, tags[$urandom_range(0, 5)], 1, i == n - 1);
	endtask

	initial begin
		logic [1:0] m;
		for (int i = 0; i < 8; i++) keys[i] = $urandom;
		keys[0] = 0; keys[1] = 32'hFFFF_FFFF;
		for (int i = 0; i < 6; i++) tags[i] = $urandom;
		tags[0] = 0; tags[1] = 32'hFFFF_FFFF;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: misses, empty lists, extremes, overflow, replace, mixed list
		issue(MODE_READ, keys[0], 0, 0, 0);
		issue(MODE_REMOVE, keys[1], 0, 0, 0);
		issue(MODE_QUERY, 0, 0, 0, 1);
		issue(MODE_PUT, keys[1], 0, 0, 1);
		issue(MODE_READ, keys[1], 0, 0, 0);
		issue(MODE_PUT, keys[0], tags[0], 1, 0);
		issue(MODE_PUT, keys[0], tags[1], 1, 1);
		issue(MODE_READ, keys[0], 0, 0, 0);
		for (int i = 0; i < 9; i++) issue(MODE_PUT, keys[2], tags[i % 6], 1, i == 8);
		issue(MODE_PUT, keys[2], tags[1], 1, 0);
		issue(MODE_QUERY, keys[2], tags[1], 1, 1);
		issue(MODE_PUT, keys[0], tags[2], 1, 0);
		issue(MODE_READ, keys[0], 0, 0, 0);
		issue(MODE_PUT, keys[0], tags[1], 1, 1);
		issue(MODE_QUERY, 0, tags[5], 1, 1);
		issue(MODE_REMOVE, keys[1], 0, 0, 0);
		issue(MODE_QUERY, 0, 0, 0, 1);
		go_quiet();

		// fill the table to capacity, overfill, then replace at full
		for (int i = 0; i < TABLE_ENTRIES + 2; i++)
			issue(MODE_PUT, $urandom, tags[i % 6], 1, 1);
		issue(MODE_PUT, keys[0], tags[3], 1, 1);
		issue(MODE_QUERY, 0, 0, 0, 1);
		go_quiet();
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			issue(MODE_QUERY, 0, 0, 0, 1);
			go_quiet();
			break;
		end

		// random sequences: mostly well-formed lists over a small key pool
		while (n_items < 370) begin
			if (n_items > 320) idling = 0;
			case ($urandom_range(0, 9))
				0, 1, 2: send_list(MODE_PUT, keys[$urandom_range(0, 7)], $urandom_range(0, 9));
				3, 4:    send_list(MODE_QUERY, $urandom, $urandom_range(0, 3));
				5:       issue(MODE_READ, keys[$urandom_range(0, 7)], $urandom, $urandom, $urandom);
				6:       issue(MODE_REMOVE, keys[$urandom_range(0, 7)], $urandom, $urandom, $urandom);
				7: begin
					m = $urandom;
					issue(m, $urandom, $urandom, $urandom, $urandom);
				end
				8:       send_list(MODE_PUT, $urandom, $urandom_range(1, 2));
				default: issue(MODE_PUT, keys[$urandom_range(0, 7)], tags[$urandom_range(0, 5)], 1, 0);
			endcase
			if ($urandom_range(0, 60) == 0) go_quiet();
		end

		go_quiet();
		repeat (20) @(posedge clk);
		$display("covered puts, reads, removes and subset queries: %0d items", n_items);
		$display("including empty lists, overflow, full table and key/tag extremes");
		if (fails == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/skt_pkg.sv
rtl/skt_cell.sv
rtl/sorted_key_tag_table.sv
tb/sv/skt_checker.sv
tb/sv/tb_sorted_key_tag_table.sv
